// File: design/ps2mpt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int RX_W         = 8;
  localparam int POS_W        = 12;
  localparam int MAX_W        = 12;
  localparam int SCROLL_W     = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_FIELDS_W = 2 * POS_W + 3 + SCROLL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int COORD_WIDTH_DEFAULT = 12;

  // byte 0 bit positions
  localparam int BIT_BTN_L = 0;
  localparam int BIT_BTN_R = 1;
  localparam int BIT_BTN_M = 2;
  localparam int BIT_SYNC  = 3;

  localparam logic [MAX_W-1:0] MAX_X_RESET = MAX_W'(1024 - 1);
  localparam logic [MAX_W-1:0] MAX_Y_RESET = MAX_W'(768 - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_MODE = 2'd0,
    CFG_MAX_X      = 2'd1,
    CFG_MAX_Y      = 2'd2
  } cfg_idx_t;

  // completed packet, as seen by the tracker
  typedef struct packed {
    logic          done;       // packet completed by this byte
    logic          wheel_upd;  // fourth byte present and used
    logic [RX_W-1:0] b0;
    logic [RX_W-1:0] b1;
    logic [RX_W-1:0] b2;
    logic [RX_W-1:0] b3;
  } pkt_t;

endpackage

// File: design/ps2mpt_assembler.sv
// ----------------------------------------------------------------------------
// ps2mpt_assembler
// Byte counter and packet byte store; flags packet completion.
// ----------------------------------------------------------------------------
module ps2mpt_assembler
  import ps2mpt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic            data_ready,
  input  logic            from_aux,
  input  logic [RX_W-1:0] rx_byte,
  input  logic            wheel_mode,
  output pkt_t            pkt
);

  logic [1:0]      byte_count_r, byte_count_nxt;
  logic [RX_W-1:0] pkt_bytes_r [3];
  logic            take;
  logic            full;

  assign take = fire && data_ready && from_aux;
  // wheel mode completes on byte 3; standard mode on byte 2 or later
  assign full = wheel_mode ? (byte_count_r == 2'd3) : (byte_count_r >= 2'd2);

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (take) begin
      byte_count_nxt = full ? 2'd0 : byte_count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 2'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  // count never reaches 3 when a byte is stored
  always_ff @(posedge clk) begin
    if (take && !full) begin
      pkt_bytes_r[byte_count_r] <= rx_byte;
    end
  end

  always_comb begin
    pkt.done      = take && full;
    pkt.wheel_upd = wheel_mode && (byte_count_r == 2'd3);
    pkt.b0        = pkt_bytes_r[0];
    pkt.b1        = pkt_bytes_r[1];
    pkt.b2        = (byte_count_r == 2'd2) ? rx_byte : pkt_bytes_r[2];
    pkt.b3        = rx_byte;
  end

endmodule

// File: design/ps2mpt_tracker.sv
// ----------------------------------------------------------------------------
// ps2mpt_tracker
// Cursor, button and wheel state with clamping; owns the result register.
// ----------------------------------------------------------------------------
module ps2mpt_tracker
  import ps2mpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pkt_t                pkt,
  input  logic [MAX_W-1:0]    max_x,
  input  logic [MAX_W-1:0]    max_y,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [POS_W-1:0]    pos_x,
  output logic [POS_W-1:0]    pos_y,
  output logic [2:0]          buttons,
  output logic [SCROLL_W-1:0] scroll_total
);

  localparam int CALC_W = ((COORD_WIDTH > MAX_W) ? COORD_WIDTH : MAX_W) + 2;
  localparam logic [CALC_W-1:0] COORD_MASK =
    {{(CALC_W - COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

  logic [COORD_WIDTH-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_WIDTH-1:0] cursor_y_r, cursor_y_nxt;
  logic [2:0]             buttons_r, buttons_nxt;
  logic [SCROLL_W-1:0]    wheel_r, wheel_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]       pos_x_r, pos_y_r;
  logic [2:0]             btn_out_r;
  logic [SCROLL_W-1:0]    scroll_r;

  logic                   upd;
  logic [CALC_W-1:0]      lim_x, lim_y, mx_ext, my_ext;
  logic signed [CALC_W-1:0] nx, ny;

  assign upd = pkt.done && pkt.b0[BIT_SYNC];

  assign mx_ext = CALC_W'(max_x);
  assign my_ext = CALC_W'(max_y);
  assign lim_x  = (mx_ext > COORD_MASK) ? COORD_MASK : mx_ext;
  assign lim_y  = (my_ext > COORD_MASK) ? COORD_MASK : my_ext;

  assign nx = signed'(CALC_W'(cursor_x_r)) + CALC_W'(signed'(pkt.b1));
  assign ny = signed'(CALC_W'(cursor_y_r)) - CALC_W'(signed'(pkt.b2));

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    buttons_nxt  = buttons_r;
    wheel_nxt    = wheel_r;
    if (upd) begin
      priority if (nx[CALC_W-1])       cursor_x_nxt = '0;
      else if (unsigned'(nx) > lim_x)  cursor_x_nxt = COORD_WIDTH'(lim_x);
      else                             cursor_x_nxt = COORD_WIDTH'(unsigned'(nx));
      priority if (ny[CALC_W-1])       cursor_y_nxt = '0;
      else if (unsigned'(ny) > lim_y)  cursor_y_nxt = COORD_WIDTH'(lim_y);
      else                             cursor_y_nxt = COORD_WIDTH'(unsigned'(ny));
      buttons_nxt = {pkt.b0[BIT_BTN_M], pkt.b0[BIT_BTN_R], pkt.b0[BIT_BTN_L]};
      if (pkt.wheel_upd) begin
        // wheel byte counts down the total
        wheel_nxt = wheel_r - SCROLL_W'(signed'(pkt.b3));
      end
    end
  end

  assign out_valid_nxt = upd ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      buttons_r   <= '0;
      wheel_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      buttons_r   <= buttons_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      pos_x_r   <= POS_W'(cursor_x_nxt);
      pos_y_r   <= POS_W'(cursor_y_nxt);
      btn_out_r <= buttons_nxt;
      scroll_r  <= wheel_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign pos_x        = pos_x_r;
  assign pos_y        = pos_y_r;
  assign buttons      = btn_out_r;
  assign scroll_total = scroll_r;

endmodule

// File: design/ps2_mouse_packet_tracker_unit.sv
// Path: a packet's last byte passes the input register, then the result
//   register, before its result is shown.
// Throughput: one byte per cycle while the result register is free or being drained;
//   the byte counter and cursor state update in a single pass between the input register and the result register.
// Reset (rst_n, synchronous, active low): counter, cursor, buttons and wheel
//   total clear; wheel_mode = 0, max_x = 1023, max_y = 767.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Collects mouse bytes into 3- or 4-byte packets and tracks cursor, buttons
// and wheel total, one result per packet with a valid sync bit.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit
  import ps2mpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] data_ready, [1] from_aux
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] pos_x, [23:12] pos_y,
                                             // [24] btn_left, [25] btn_right,
                                             // [26] btn_middle,
                                             // [58:27] scroll_total, rest 0
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [MAX_W-1:0]       cfg_data
);

  // configuration registers
  logic             wheel_mode_r;
  logic [MAX_W-1:0] max_x_r, max_y_r;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_ready_r, s1_aux_r;
  logic [RX_W-1:0]  s1_byte_r;

  logic             advance, fire, in_xfer;
  pkt_t             pkt;
  logic [POS_W-1:0] pos_x, pos_y;
  logic [2:0]       buttons;
  logic [SCROLL_W-1:0] scroll_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      max_x_r      <= MAX_X_RESET;
      max_y_r      <= MAX_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WHEEL_MODE: wheel_mode_r <= cfg_data[0];
        CFG_MAX_X:      max_x_r      <= cfg_data;
        CFG_MAX_Y:      max_y_r      <= cfg_data;
        default:        ;  // unmapped index: write ignored
      endcase
    end
  end

  // The held byte moves on whenever the result register is free or being
  // drained; bytes that produce no result could go anyway, but this keeps
  // the rule simple.
  assign advance   = !out_tvalid || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_xfer ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ready_r <= in_tuser[0];
      s1_aux_r   <= in_tuser[1];
      s1_byte_r  <= in_tdata[RX_W-1:0];
    end
  end

  ps2mpt_assembler u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_ready (s1_ready_r),
    .from_aux   (s1_aux_r),
    .rx_byte    (s1_byte_r),
    .wheel_mode (wheel_mode_r),
    .pkt        (pkt)
  );

  ps2mpt_tracker #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_trk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pkt          (pkt),
    .max_x        (max_x_r),
    .max_y        (max_y_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .buttons      (buttons),
    .scroll_total (scroll_total)
  );

  assign out_tdata = OUT_TDATA_W'({scroll_total, buttons, pos_y, pos_x});

endmodule

// File: design/ps2mpt_checker.sv
// ----------------------------------------------------------------------------
// ps2mpt_checker
// Port-level checks on the packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mpt_checker
  import ps2mpt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // pad bits above the fields stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
    else $error("result pad bits not zero");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_ps2mpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: verif/ps2_mouse_packet_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit_tb
// Self-checking bench for the PS/2 mouse packet tracker. Controller bytes are
// streamed in from a queue, a cycle-free tracker model predicts every cursor
// report, and the result stream is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit_tb;
  import ps2mpt_pkg::*;

  // one controller byte with its status flags
  typedef struct packed {
    logic            ready;
    logic            aux;
    logic [RX_W-1:0] data;
  } ctrl_byte_t;

  // one cursor report
  typedef struct packed {
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic                btn_left;
    logic                btn_right;
    logic                btn_middle;
    logic [SCROLL_W-1:0] scroll_total;
  } mouse_report_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [7:0] rx_byte
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;   // [0] data_ready, [1] from_aux
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [11:0] pos_x, [23:12] pos_y,
                                             // [24] btn_left, [25] btn_right,
                                             // [26] btn_middle,
                                             // [58:27] scroll_total
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_WHEEL_MODE;
  logic [MAX_W-1:0]       cfg_data   = '0;

  ps2_mouse_packet_tracker_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Tracker model state. Mirrors the block's registers and its reset values.
  // --------------------------------------------------------------------------
  logic                wheel_on  = 1'b0;
  logic [MAX_W-1:0]    lim_x     = MAX_X_RESET;
  logic [MAX_W-1:0]    lim_y     = MAX_Y_RESET;
  int                  held_cnt  = 0;
  logic [RX_W-1:0]     held [3];
  logic [POS_W-1:0]    cur_x     = '0;
  logic [POS_W-1:0]    cur_y     = '0;
  logic [2:0]          btns      = '0;
  logic [SCROLL_W-1:0] wheel_sum = '0;

  ctrl_byte_t    byte_q [$];    // bytes waiting for the driver
  mouse_report_t report_q [$];  // reports predicted but not yet seen

  int n_pushed    = 0;  // bytes queued by the stimulus
  int n_taken     = 0;  // bytes transferred into the block
  int n_mouse     = 0;  // queued bytes that the block actually uses
  int errors      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit tx_pause    = 1'b0;
  int stall_req   = 0;  // bumped by the stimulus to ask for a long stall
  int stall_ack   = 0;
  int stall_left  = 0;

  ctrl_byte_t    nxt_byte;
  mouse_report_t exp_rep;

  // Coordinate width equals the register width here, so the register value is
  // already the effective limit.
  function automatic logic [POS_W-1:0] clamp_pos(int v, logic [MAX_W-1:0] lim);
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return v[POS_W-1:0];
  endfunction

  // Advance the tracker by one transferred byte; queue a report if a packet
  // with a good sync bit completes.
  task automatic track_byte(logic ready, logic aux, logic [RX_W-1:0] data);
    int              pkt_len;
    int              slot;
    logic [RX_W-1:0] y_byte;
    mouse_report_t   rep;
    if (!(ready && aux)) return;
    pkt_len = wheel_on ? 4 : 3;
    slot    = held_cnt;
    if (slot + 1 < pkt_len) begin
      held[slot] = data;
      held_cnt   = slot + 1;
      return;
    end
    // packet done; a byte past the end after a mode switch is dropped
    held_cnt = 0;
    y_byte   = (slot == 2) ? data : held[2];
    if (!held[0][BIT_SYNC]) return;
    cur_x = clamp_pos(int'(cur_x) + int'($signed(held[1])), lim_x);
    cur_y = clamp_pos(int'(cur_y) - int'($signed(y_byte)), lim_y);
    btns  = {held[0][BIT_BTN_M], held[0][BIT_BTN_R], held[0][BIT_BTN_L]};
    if (pkt_len == 4 && slot == 3) wheel_sum -= {{24{data[7]}}, data};
    rep.pos_x        = cur_x;
    rep.pos_y        = cur_y;
    rep.btn_left     = btns[0];
    rep.btn_right    = btns[1];
    rep.btn_middle   = btns[2];
    rep.scroll_total = wheel_sum;
    report_q.push_back(rep);
  endtask

  // --------------------------------------------------------------------------
  // Driver: keeps in_tvalid up until the transfer, then offers the next byte
  // unless the sender idles or is paused. The model advances on each transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_byte(in_tuser[0], in_tuser[1], in_tdata);
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
          nxt_byte = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt_byte.data;
          in_tuser  <= {nxt_byte.aux, nxt_byte.ready};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction and
  // drives out_tready, including the long hold-off on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result with no prediction pending: tdata %h", out_tdata);
          errors++;
        end else begin
          exp_rep = report_q.pop_front();
          if (out_tdata[POS_W-1:0] !== exp_rep.pos_x) begin
            $error("pos_x: expected %0d, got %0d", exp_rep.pos_x, out_tdata[POS_W-1:0]);
            errors++;
          end
          if (out_tdata[2*POS_W-1:POS_W] !== exp_rep.pos_y) begin
            $error("pos_y: expected %0d, got %0d", exp_rep.pos_y,
                   out_tdata[2*POS_W-1:POS_W]);
            errors++;
          end
          if (out_tdata[2*POS_W] !== exp_rep.btn_left) begin
            $error("btn_left: expected %0d, got %0d", exp_rep.btn_left, out_tdata[2*POS_W]);
            errors++;
          end
          if (out_tdata[2*POS_W+1] !== exp_rep.btn_right) begin
            $error("btn_right: expected %0d, got %0d", exp_rep.btn_right,
                   out_tdata[2*POS_W+1]);
            errors++;
          end
          if (out_tdata[2*POS_W+2] !== exp_rep.btn_middle) begin
            $error("btn_middle: expected %0d, got %0d", exp_rep.btn_middle,
                   out_tdata[2*POS_W+2]);
            errors++;
          end
          if (out_tdata[2*POS_W+3 +: SCROLL_W] !== exp_rep.scroll_total) begin
            $error("scroll_total: expected %0d, got %0d", $signed(exp_rep.scroll_total),
                   $signed(out_tdata[2*POS_W+3 +: SCROLL_W]));
            errors++;
          end
        end
      end
      if (stall_req != stall_ack) begin
        stall_ack  = stall_req;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_byte(bit ready, bit aux, logic [RX_W-1:0] data);
    ctrl_byte_t b;
    b.ready = ready;
    b.aux   = aux;
    b.data  = data;
    byte_q.push_back(b);
    n_pushed++;
    if (ready && aux) n_mouse++;
  endtask

  // byte that the block must ignore: not ready, not from the mouse, or both
  task automatic push_noise();
    int sel;
    sel = $urandom_range(2);
    push_byte(sel == 1, sel == 2, RX_W'($urandom));
  endtask

  function automatic logic [RX_W-1:0] pick_delta();
    case ($urandom_range(7))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'hFF;
      default: return RX_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets with random content, some noise in between,
  // a few without the sync bit and a few cut short.
  task automatic push_rand_packet(bit wheel);
    int              n;
    logic [RX_W-1:0] b;
    n = wheel ? 4 : 3;
    if ($urandom_range(99) < 3) n = $urandom_range(n - 1, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 12) push_noise();
      if (k == 0) begin
        b = RX_W'($urandom);
        if ($urandom_range(99) < 90) b[BIT_SYNC] = 1'b1;
      end else begin
        b = pick_delta();
      end
      push_byte(1'b1, 1'b1, b);
    end
  endtask

  // Wait until every queued byte has been taken and every report has come,
  // then let the block's pipeline settle.
  task automatic drain(int tail);
    while (n_taken != n_pushed || report_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(cfg_idx_t idx, logic [MAX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WHEEL_MODE: wheel_on = val[0];
      CFG_MAX_X:      lim_x    = val;
      CFG_MAX_Y:      lim_y    = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config (3-byte packets, 1023 x 767), no idling.
    push_byte(1'b0, 1'b1, 8'hFF);     // not ready
    push_byte(1'b1, 1'b0, 8'h08);     // keyboard byte
    push_byte(1'b0, 1'b0, 8'h00);
    push_byte(1'b1, 1'b1, 8'h0F);     // all buttons, largest deltas
    push_byte(1'b1, 1'b1, 8'h7F);
    push_byte(1'b1, 1'b1, 8'h80);
    push_byte(1'b1, 1'b1, 8'hC9);     // overflow bits set but unused
    push_byte(1'b1, 1'b1, 8'h80);     // X goes negative -> clamp to zero
    push_byte(1'b1, 1'b1, 8'h7F);
    push_byte(1'b1, 1'b1, 8'h07);     // no sync bit: packet dropped
    push_byte(1'b1, 1'b1, 8'h10);
    push_byte(1'b1, 1'b1, 8'h10);
    drain(4);

    // wheel packets with X pinned at zero and the widest Y range
    write_reg(CFG_MAX_X, 12'd0);
    write_reg(CFG_MAX_Y, 12'd4095);
    write_reg(CFG_WHEEL_MODE, MAX_W'(1));
    push_byte(1'b1, 1'b1, 8'h0A);
    push_byte(1'b1, 1'b1, 8'h7F);
    push_byte(1'b1, 1'b1, 8'h80);
    push_byte(1'b1, 1'b1, 8'h80);     // most negative wheel step
    push_byte(1'b1, 1'b1, 8'h0C);
    push_byte(1'b1, 1'b1, 8'h01);
    push_byte(1'b1, 1'b1, 8'h81);
    push_byte(1'b1, 1'b1, 8'h7F);
    // wheel mode dropped with three bytes held: next byte closes a 3-byte
    // packet from the held bytes and is itself thrown away
    push_byte(1'b1, 1'b1, 8'h09);
    push_byte(1'b1, 1'b1, 8'h05);
    push_byte(1'b1, 1'b1, 8'hFB);
    drain(4);
    write_reg(CFG_WHEEL_MODE, MAX_W'(0));
    push_byte(1'b1, 1'b1, 8'h55);
    // and the other way: two bytes held, then wheel mode switched on
    push_byte(1'b1, 1'b1, 8'h08);
    push_byte(1'b1, 1'b1, 8'h02);
    drain(4);
    write_reg(CFG_WHEEL_MODE, MAX_W'(1));
    push_byte(1'b1, 1'b1, 8'h03);
    push_byte(1'b1, 1'b1, 8'hFF);
    drain(4);

    // Random phases: sender-light/receiver-heavy idling, then the reverse,
    // then none; each idling pattern runs in both packet modes.
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph / 2 == 0) ? 13 : (ph / 2 == 1) ? 81 : 0;
      rx_idle_pct = (ph / 2 == 0) ? 81 : (ph / 2 == 1) ? 13 : 0;
      write_reg(CFG_WHEEL_MODE, MAX_W'(ph % 2));
      write_reg(CFG_MAX_X, (ph == 0) ? 12'd4095 : (ph == 1) ? 12'd0
                                     : MAX_W'($urandom_range(4095)));
      write_reg(CFG_MAX_Y, (ph == 0) ? 12'd0 : (ph == 1) ? 12'd4095
                                     : MAX_W'($urandom_range(4095)));
      base = n_mouse;
      while (n_mouse < base + 66) push_rand_packet(ph % 2 == 1);
      drain(4);
    end

    // Back-pressure: long receiver hold-off while the sender keeps offering,
    // then a sender pause until all reports are back.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_MAX_X, MAX_X_RESET);
    write_reg(CFG_MAX_Y, MAX_Y_RESET);
    stall_req++;
    repeat (30) push_rand_packet(wheel_on);
    base = n_pushed;
    while (n_taken < base - 30) @(posedge clk);
    tx_pause = 1'b1;
    while (report_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    tx_pause = 1'b0;

    drain(8);
    if (errors == 0) begin
      $display("ps2_mouse_packet_tracker_unit verification clean");
    end else begin
      $display("ps2_mouse_packet_tracker_unit verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("ps2_mouse_packet_tracker_unit verification failed");
    $finish;
  end

endmodule
